FILE: hdl/dbfe_pkg.sv
// Shared types, constants and packet-building function for the burst frame encoder.
// Used by every module in hdl; depends on nothing else.
`default_nettype none

package dbfe_pkg;

    localparam int MOTOR_COUNT   = 4;
    localparam int THROTTLE_W    = 11;
    localparam int DUTY_W        = 16;
    localparam int PACKET_BITS   = 16;
    localparam int GAP_SLOTS     = 2;
    localparam int SLOT_TOTAL    = PACKET_BITS + GAP_SLOTS;
    localparam int SLOT_W        = $clog2(SLOT_TOTAL);
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 16'd135;
    localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 16'd67;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_TELEMETRY = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_DUTY  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_DUTY = 2'd2;

    typedef struct packed {
        logic [THROTTLE_W-1:0] throttle_m1;
        logic [THROTTLE_W-1:0] throttle_m2;
        logic [THROTTLE_W-1:0] throttle_m3;
        logic [THROTTLE_W-1:0] throttle_m4;
    } frame_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_m1;
        logic [DUTY_W-1:0] duty_m2;
        logic [DUTY_W-1:0] duty_m3;
        logic [DUTY_W-1:0] duty_m4;
        logic              last_slot;
    } result_t;

    // Slot control handed from the sequencer to the merge stage.
    typedef struct packed {
        logic emit;
        logic in_packet;
        logic last;
    } slot_ctrl_t;

    // Twelve-bit word is the throttle with the telemetry bit below it; the
    // checksum is the XOR of its three nibbles.
    function automatic logic [PACKET_BITS-1:0] build_packet(
        input logic [THROTTLE_W-1:0] throttle,
        input logic                  telemetry
    );
        logic [11:0] word;
        logic [3:0]  csum;
        word = {throttle, telemetry};
        csum = word[3:0] ^ word[7:4] ^ word[11:8];
        return {word, csum};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dbfe_lane.sv
// One motor lane: builds the packet for its throttle and shifts it out MSB first.
// Depends on dbfe_pkg.
`default_nettype none

module dbfe_lane
    import dbfe_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire logic                  shift,
    input  wire logic [THROTTLE_W-1:0] throttle,
    input  wire logic                  telemetry,
    output logic                       packet_bit
);

    logic [PACKET_BITS-1:0] packet_reg;
    logic [PACKET_BITS-1:0] packet_next;

    always_comb
    begin
        packet_next = packet_reg;
        if (load)
        begin
            packet_next = build_packet(throttle, telemetry);
        end
        else if (shift)
        begin
            packet_next = {packet_reg[PACKET_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_reg <= '0;
        end
        else
        begin
            packet_reg <= packet_next;
        end
    end

    assign packet_bit = packet_reg[PACKET_BITS-1];

endmodule

`default_nettype wire

FILE: hdl/dbfe_merge.sv
// Merge stage: turns the lane bits into compare values and registers one result.
// Depends on dbfe_pkg.
`default_nettype none

module dbfe_merge
    import dbfe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire slot_ctrl_t             ctrl,
    input  wire logic [MOTOR_COUNT-1:0] lane_bits,
    input  wire logic [DUTY_W-1:0]      one_duty,
    input  wire logic [DUTY_W-1:0]      zero_duty,
    output result_t                     result,
    output logic                        result_strobe
);

    result_t result_reg;
    result_t result_next;
    logic    strobe_reg;
    logic [MOTOR_COUNT-1:0][DUTY_W-1:0] duty;

    always_comb
    begin
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            if (!ctrl.in_packet)
            begin
                duty[m] = '0;
            end
            else if (lane_bits[m])
            begin
                duty[m] = one_duty;
            end
            else
            begin
                duty[m] = zero_duty;
            end
        end
        result_next.duty_m1   = duty[0];
        result_next.duty_m2   = duty[1];
        result_next.duty_m3   = duty[2];
        result_next.duty_m4   = duty[3];
        result_next.last_slot = ctrl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            result_reg <= result_next;
        end
    end

    assign result        = result_reg;
    assign result_strobe = strobe_reg;

endmodule

`default_nettype wire

FILE: hdl/dshot_burst_frame_encoder.sv
// Top level of the burst frame encoder: slot sequencer, config registers, four lanes
// and the merge stage. Depends on dbfe_pkg, dbfe_lane and dbfe_merge.
`default_nettype none

// A frame item is taken when start is high and busy is low. It yields 18 results
// (16 packet bits, then 2 zero-duty gap slots), one per cycle on consecutive cycles,
// after the accepting edge loads the lanes and the merge stage registers each one;
// result_strobe marks each and there is no back-pressure. The slot counter sets the
// pace: busy drops during the final slot, so a new frame can be taken then and the
// next burst follows with no gap. Configuration writes belong between frames.
module dshot_burst_frame_encoder
    import dbfe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire frame_t                 frame,
    output result_t                     result,
    output logic                        result_strobe,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOT_TOTAL - 1);
    localparam logic [SLOT_W:0]   PACKET_END = (SLOT_W + 1)'(PACKET_BITS);

    logic                  active_reg;
    logic                  active_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic                  telemetry_reg;
    logic [DUTY_W-1:0]     one_duty_reg;
    logic [DUTY_W-1:0]     zero_duty_reg;
    logic                  accept;
    logic                  at_last;
    slot_ctrl_t            ctrl;
    logic [MOTOR_COUNT-1:0]                 lane_bits;
    logic [MOTOR_COUNT-1:0][THROTTLE_W-1:0] throttle;

    assign at_last = (slot_reg == LAST_SLOT);
    assign busy    = active_reg && !at_last;
    assign accept  = start && !busy;

    always_comb
    begin
        active_next = active_reg;
        slot_next   = slot_reg;
        if (accept)
        begin
            active_next = 1'b1;
            slot_next   = '0;
        end
        else if (active_reg)
        begin
            if (at_last)
            begin
                active_next = 1'b0;
                slot_next   = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            slot_reg      <= '0;
            telemetry_reg <= 1'b0;
            one_duty_reg  <= ONE_DUTY_RESET;
            zero_duty_reg <= ZERO_DUTY_RESET;
        end
        else
        begin
            active_reg <= active_next;
            slot_reg   <= slot_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TELEMETRY: telemetry_reg <= cfg_data[0];
                    CFG_ONE_DUTY:  one_duty_reg  <= cfg_data;
                    CFG_ZERO_DUTY: zero_duty_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    assign throttle[0] = frame.throttle_m1;
    assign throttle[1] = frame.throttle_m2;
    assign throttle[2] = frame.throttle_m3;
    assign throttle[3] = frame.throttle_m4;

    for (genvar m = 0; m < MOTOR_COUNT; m++)
    begin : g_lane
        dbfe_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .load       (accept),
            .shift      (active_reg),
            .throttle   (throttle[m]),
            .telemetry  (telemetry_reg),
            .packet_bit (lane_bits[m])
        );
    end

    assign ctrl.emit      = active_reg;
    assign ctrl.in_packet = ({1'b0, slot_reg} < PACKET_END);
    assign ctrl.last      = at_last;

    dbfe_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .lane_bits     (lane_bits),
        .one_duty      (one_duty_reg),
        .zero_duty     (zero_duty_reg),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // A frame's first result follows the accepting edge, once the merge stage has registered it.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##1 result_strobe)
        else $error("accepted frame produced no first result");

    // The slot counter never runs past the final slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot counter out of range");

    // Results of one frame come on consecutive cycles until the last one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last_slot) |=> result_strobe)
        else $error("gap inside a frame burst");

    // The final gap slot carries zero duty on every motor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_slot && (GAP_SLOTS != 0)) |->
        (result.duty_m1 == '0 && result.duty_m2 == '0 &&
         result.duty_m3 == '0 && result.duty_m4 == '0))
        else $error("nonzero duty in a gap slot");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for dshot_burst_frame_encoder: predicts the 18 duty slots of each
// frame and compares them with the block's output as it streams out.
// Depends on dbfe_pkg and the encoder RTL in hdl.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dbfe_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int MAX_REPORTS     = 40;
    localparam logic [THROTTLE_W-1:0] THROTTLE_MAX = '1;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    frame_t                 frame;
    result_t                result;
    logic                   result_strobe;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the configuration registers.
    logic              tlm_bit;
    logic [DUTY_W-1:0] duty_one;
    logic [DUTY_W-1:0] duty_zero;

    result_t slot_q[$];
    int      error_count;
    int      idle_cycles;

    dshot_burst_frame_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .frame         (frame),
        .result        (result),
        .result_strobe (result_strobe),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Twelve-bit value is the throttle with the telemetry bit appended; the low
    // nibble of the packet folds the three nibbles of that value together.
    function automatic logic [PACKET_BITS-1:0] dshot_packet(logic [THROTTLE_W-1:0] thr,
                                                            logic tlm);
        logic [11:0] value;
        logic [3:0]  crc;
        value = {thr, tlm};
        crc = '0;
        for (int n = 0; n < 3; n++)
        begin
            crc = crc ^ value[n*4 +: 4];
        end
        return {value, crc};
    endfunction

    function automatic void predict_frame_slots(frame_t f);
        logic [PACKET_BITS-1:0] pkt [MOTOR_COUNT];
        logic [DUTY_W-1:0]      duty [MOTOR_COUNT];
        result_t                slot;
        pkt[0] = dshot_packet(f.throttle_m1, tlm_bit);
        pkt[1] = dshot_packet(f.throttle_m2, tlm_bit);
        pkt[2] = dshot_packet(f.throttle_m3, tlm_bit);
        pkt[3] = dshot_packet(f.throttle_m4, tlm_bit);
        for (int s = 0; s < SLOT_TOTAL; s++)
        begin
            for (int m = 0; m < MOTOR_COUNT; m++)
            begin
                if (s < PACKET_BITS)
                    duty[m] = pkt[m][PACKET_BITS-1-s] ? duty_one : duty_zero;
                else
                    duty[m] = '0;
            end
            slot.duty_m1   = duty[0];
            slot.duty_m2   = duty[1];
            slot.duty_m3   = duty[2];
            slot.duty_m4   = duty[3];
            slot.last_slot = (s == SLOT_TOTAL - 1);
            slot_q.push_back(slot);
        end
    endfunction

    function automatic void check_field(string name, logic [DUTY_W-1:0] want,
                                        logic [DUTY_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_strobe)
        begin
            if (slot_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected result: expected none, actual %h", $time, result);
            end
            else
            begin
                want = slot_q.pop_front();
                check_field("duty_m1", want.duty_m1, result.duty_m1);
                check_field("duty_m2", want.duty_m2, result.duty_m2);
                check_field("duty_m3", want.duty_m3, result.duty_m3);
                check_field("duty_m4", want.duty_m4, result.duty_m4);
                check_field("last_slot", DUTY_W'(want.last_slot), DUTY_W'(result.last_slot));
            end
        end
    end

    // Ends the run if neither an item nor a result is accepted for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Entered at a rising edge; leaves start high so a following item can go
    // out back to back.
    task automatic send_frame(frame_t f);
        start <= 1'b1;
        frame <= f;
        do
            @(posedge clk);
        while (busy);
        predict_frame_slots(f);
    endtask

    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (slot_q.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_TELEMETRY: tlm_bit   = data[0];
            CFG_ONE_DUTY:  duty_one  = data;
            CFG_ZERO_DUTY: duty_zero = data;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [THROTTLE_W-1:0] random_throttle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return THROTTLE_MAX;
            default: return THROTTLE_W'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        f.throttle_m1 = random_throttle();
        f.throttle_m2 = random_throttle();
        f.throttle_m3 = random_throttle();
        f.throttle_m4 = random_throttle();
        return f;
    endfunction

    function automatic logic [DUTY_W-1:0] random_duty();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return DUTY_W'($urandom);
        endcase
    endfunction

    // Frames at the reset configuration, covering the throttle extremes.
    task automatic test_reset_defaults();
        send_frame('{default: '0});
        send_frame('{default: THROTTLE_MAX});
        hold_off(5);
        send_frame('{11'h555, 11'h2aa, 11'h555, 11'h2aa});
        send_frame('{11'h001, 11'h400, 11'h030, 11'h7fe});
        hold_off(12);
        send_frame(random_frame());
        wait_for_results();
    endtask

    task automatic test_register_writes();
        // Wide data on the one-bit register keeps only its low bit.
        write_reg(CFG_TELEMETRY, 16'hffff);
        write_reg(CFG_ONE_DUTY, 16'hffff);
        write_reg(CFG_ZERO_DUTY, 16'h0000);
        send_frame('{default: '0});
        send_frame('{default: THROTTLE_MAX});
        wait_for_results();
        write_reg(CFG_TELEMETRY, 16'hfffe);
        write_reg(CFG_ONE_DUTY, 16'h0000);
        write_reg(CFG_ZERO_DUTY, 16'hffff);
        send_frame('{11'h7ff, 11'h000, 11'h3c3, 11'h43c});
        send_frame(random_frame());
        wait_for_results();
        // The spare index is not a register, so this write changes nothing.
        write_reg(CFG_SPARE_INDEX, 16'h5a5a);
        send_frame('{11'h123, 11'h456, 11'h789, 11'h0ab});
        wait_for_results();
        write_reg(CFG_TELEMETRY, 16'h0003);
        write_reg(CFG_TELEMETRY, 16'h0001);
        send_frame(random_frame());
        wait_for_results();
    endtask

    task automatic test_back_to_back();
        write_reg(CFG_ONE_DUTY, 16'd135);
        write_reg(CFG_ZERO_DUTY, 16'd67);
        repeat (6) send_frame(random_frame());
        wait_for_results();
    endtask

    task automatic test_random_frames();
        int sent;
        int burst;
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_TELEMETRY, CFG_DATA_W'($urandom));
            write_reg(CFG_ONE_DUTY, random_duty());
            write_reg(CFG_ZERO_DUTY, random_duty());
            if ($urandom_range(0, 1))
                write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
            sent = 0;
            while (sent < 48)
            begin
                burst = $urandom_range(1, 8);
                for (int i = 0; i < burst && sent < 48; i++)
                begin
                    send_frame(random_frame());
                    sent++;
                end
                // Phase one runs with no gaps at all.
                if (phase != 1 && $urandom_range(0, 3) != 0)
                    hold_off($urandom_range(1, 25));
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        frame       <= '0;
        cfg_we      <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        tlm_bit     = 1'b0;
        duty_one    = ONE_DUTY_RESET;
        duty_zero   = ZERO_DUTY_RESET;
        error_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_writes();
        test_back_to_back();
        test_random_frames();

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
